/* hdl/iasmd_pkg.sv */
// package with shared types and constants for the integer arithmetic unit
package iasmd_pkg;
  localparam int Width = 32;
  localparam int OpW = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef logic [Width-1:0] word_t;

  typedef struct packed {
    logic  vld;
    op_t   op;
    word_t a;
    word_t b;
    word_t acc;
    word_t rem;
  } lane_t;
endpackage

/* hdl/integer_add_sub_mul_div_unit.sv */
// top level of the pipelined integer add, subtract, multiply and divide unit
//
// a request carries in_req_type (0 add, 1 subtract, 2 multiply, 3 divide)
// and two 32-bit operands on a valid/ready channel; each request gives one
// result, out_main_result and out_remainder_out, on a valid/ready channel.
// the remainder is zero except for divide. divide by zero gives an all-ones
// quotient and the dividend as remainder.
// the datapath is a chain of 32 registered cells; each cell does one shift-add
// step of the multiply or one restoring step of the divide, so every request
// passes all cells before out_valid rises with its result.
// throughput is one request per cycle while the output is not stalled; the
// whole chain advances together.
// when the receiver stalls the chain holds; in_ready is high whenever the
// output stage is empty or being taken.
// reset (rst_n low, synchronous) clears all valid flags and drops any
// requests in flight.
module integer_add_sub_mul_div_unit import iasmd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OpW-1:0]   in_req_type,
  input  logic [Width-1:0] in_operand_a,
  input  logic [Width-1:0] in_operand_b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Width-1:0] out_main_result,
  output logic [Width-1:0] out_remainder_out
);
  localparam int IdxW = $clog2(Width);

  lane_t lanes [Width+1];
  lane_t head;
  lane_t res_r;
  logic  adv;

  assign adv = !res_r.vld || out_ready;
  assign in_ready = adv;

  always_comb begin
    head.vld = in_valid;
    head.op  = op_t'(in_req_type);
    head.a   = in_operand_a;
    head.b   = in_operand_b;
    head.acc = '0;
    head.rem = '0;
    case (op_t'(in_req_type))
      OP_ADD:  head.acc = in_operand_a + in_operand_b;
      OP_SUB:  head.acc = in_operand_a - in_operand_b;
      default: head.acc = '0;
    endcase
  end

  assign lanes[0] = head;

  for (genvar g = 0; g < Width; g++) begin : g_cell
    iasmd_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .idx   (IdxW'(g)),
      .d_in  (lanes[g]),
      .d_out (lanes[g+1])
    );
  end

  assign res_r = lanes[Width];

  assign out_valid         = res_r.vld;
  assign out_main_result   = res_r.acc;
  assign out_remainder_out = (res_r.op == OP_DIV) ? res_r.rem : '0;

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_main_result))
    else $error("result changed under stall");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  a_rem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && res_r.op != OP_DIV |-> out_remainder_out == '0)
    else $error("nonzero remainder for non-divide");
`endif
endmodule

/* hdl/iasmd_cell.sv */
// one pipeline cell: a single shift-add or restoring-divide step
module iasmd_cell import iasmd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic [$clog2(Width)-1:0] idx,
  input  lane_t                    d_in,
  output lane_t                    d_out
);
  lane_t                     d_out_r;
  lane_t                     d_out_nxt;
  logic                      top;
  logic [Width-1:0]          shr;
  logic [Width:0]            diff;
  logic [$clog2(Width)-1:0]  a_sel;

  always_comb begin
    d_out_nxt = d_in;
    top = d_in.rem[Width-1];
    // dividend bits msb first, width is a power of two
    a_sel = ~idx;
    shr = {d_in.rem[Width-2:0], d_in.a[a_sel]};
    diff = {1'b0, shr} - {1'b0, d_in.b};
    case (d_in.op)
      OP_MUL: begin
        if (d_in.b[idx]) begin
          d_out_nxt.acc = d_in.acc + (d_in.a << idx);
        end
      end
      OP_DIV: begin
        if (top || !diff[Width]) begin
          d_out_nxt.rem = diff[Width-1:0];
          d_out_nxt.acc = {d_in.acc[Width-2:0], 1'b1};
        end else begin
          d_out_nxt.rem = shr;
          d_out_nxt.acc = {d_in.acc[Width-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_out_r.vld <= 1'b0;
    end else if (en) begin
      d_out_r.vld <= d_out_nxt.vld;
    end
    if (en) begin
      d_out_r.op  <= d_out_nxt.op;
      d_out_r.a   <= d_out_nxt.a;
      d_out_r.b   <= d_out_nxt.b;
      d_out_r.acc <= d_out_nxt.acc;
      d_out_r.rem <= d_out_nxt.rem;
    end
  end

  assign d_out = d_out_r;
endmodule

/* test/tb.sv */
// testbench for the integer add, subtract, multiply and divide unit
`timescale 1ns / 100ps

module tb;
  import iasmd_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles = 40;

  typedef struct packed {
    word_t quo;
    word_t rem;
  } arith_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OpW-1:0] in_req_type = '0;
  word_t in_operand_a = '0;
  word_t in_operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  word_t out_main_result;
  word_t out_remainder_out;

  arith_res_t pending_results[$];
  int mismatches = 0;
  int unexpected = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int op_count[4];
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit done = 1'b0;

  always #2 clk = ~clk;

  integer_add_sub_mul_div_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_main_result(out_main_result), .out_remainder_out(out_remainder_out)
  );

  function automatic word_t ripple_sum(word_t x, word_t y, logic cin);
    word_t s;
    logic c;
    c = cin;
    for (int i = 0; i < Width; i++) begin
      s[i] = x[i] ^ y[i] ^ c;
      c = (x[i] & y[i]) | (c & (x[i] ^ y[i]));
    end
    return s;
  endfunction

  function automatic arith_res_t compute_result(op_t op, word_t a, word_t b);
    arith_res_t r;
    word_t rem;
    word_t quo;
    logic top;
    r = '0;
    case (op)
      OP_ADD: r.quo = ripple_sum(a, b, 1'b0);
      OP_SUB: r.quo = ripple_sum(a, ~b, 1'b1);
      OP_MUL: begin
        for (int i = 0; i < Width; i++)
          if (b[i]) r.quo = ripple_sum(r.quo, a << i, 1'b0);
      end
      default: begin
        rem = '0;
        quo = '0;
        for (int i = Width - 1; i >= 0; i--) begin
          top = rem[Width-1];
          rem = {rem[Width-2:0], a[i]};
          quo = quo << 1;
          if (top || rem >= b) begin
            rem = ripple_sum(rem, ~b, 1'b1);
            quo[0] = 1'b1;
          end
        end
        r.quo = quo;
        r.rem = rem;
      end
    endcase
    return r;
  endfunction

  task automatic send_request(op_t op, word_t a, word_t b);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(compute_result(op, a, b));
    op_count[op]++;
    requests_sent++;
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return word_t'($urandom_range(0, 15));
      3: return {1'b1, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) out_ready <= calm || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk) begin
    arith_res_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("result with no request waiting: %h %h", out_main_result, out_remainder_out);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_main_result !== exp_r.quo || out_remainder_out !== exp_r.rem) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch: expected %h %h got %h %h",
                     exp_r.quo, exp_r.rem, out_main_result, out_remainder_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no progress for %0d cycles", WatchdogLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    for (int o = 0; o < 4; o++) begin
      send_request(op_t'(o), '0, '0);
      send_request(op_t'(o), '1, '1);
      send_request(op_t'(o), '1, 32'd1);
      send_request(op_t'(o), 32'h8000_0000, '1);
      send_request(op_t'(o), 32'h1234_5678, 32'h0000_0007);
    end
    send_request(OP_DIV, 32'hdead_beef, '0);
    send_request(OP_DIV, 32'd5, 32'd9);
    send_request(OP_DIV, '1, 32'h8000_0001);
    send_request(OP_MUL, 32'h0001_0000, 32'h0001_0000);
  endtask

  task automatic test_random();
    for (int i = 0; i < 1200; i++) begin
      calm = (i >= 400 && i < 600);
      send_request(op_t'($urandom_range(0, 3)), rand_word(), rand_word());
    end
    calm = 1'b0;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    done = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    wait_drain();
    $display("covered %0d requests (add %0d, sub %0d, mul %0d, div %0d), %0d results",
             requests_sent, op_count[0], op_count[1], op_count[2], op_count[3], results_seen);
    if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d unexpected", mismatches, unexpected);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* sim.f */
hdl/iasmd_pkg.sv
hdl/iasmd_cell.sv
hdl/integer_add_sub_mul_div_unit.sv
test/tb.sv
